### hdl/mm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_pkg
// Shared types and constants of the matrix multiplier: element and index
// widths, register map, the command word to the datapath and its status word back.
// ----------------------------------------------------------------------------
package mm_pkg;

  localparam int ELEM_W = 32;
  localparam int IDX_W  = 3;
  localparam int CFG_W  = 4;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_A_ROWS = 2'd0;
  localparam logic [1:0] REG_A_COLS = 2'd1;
  localparam logic [1:0] REG_B_ROWS = 2'd2;
  localparam logic [1:0] REG_B_COLS = 2'd3;

  typedef struct packed {
    logic             we;
    logic             right;
    logic             rd;
    logic             first;
    logic             last_step;
    logic             echo;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last_of_run;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } status_t;

endpackage

### hdl/mm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_ctrl
// Sequencer: counts words into the two stores, then walks rows, columns and
// inner steps, issuing one store read per cycle to the datapath.
// ----------------------------------------------------------------------------
module mm_ctrl #(
  parameter int MAX_DIM = 8,
  parameter int ADDR_W  = 6,
  parameter int CNT_W   = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [mm_pkg::CFG_W-1:0]   a_rows_raw,
  input  logic [mm_pkg::CFG_W-1:0]   a_cols_raw,
  input  logic [mm_pkg::CFG_W-1:0]   b_rows_raw,
  input  logic [mm_pkg::CFG_W-1:0]   b_cols_raw,
  input  mm_pkg::status_t            status,
  output logic                       busy,
  output mm_pkg::cmd_t               cmd,
  output logic [ADDR_W-1:0]          waddr,
  output logic [ADDR_W-1:0]          a_addr,
  output logic [ADDR_W-1:0]          b_addr
);
  import mm_pkg::*;

  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  typedef enum logic [2:0] {
    S_LOAD  = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  load_count, load_count_next;
  logic              loading_right, loading_right_next;
  logic [IW-1:0]     i, i_next, j, j_next, k, k_next;
  logic [ADDR_W-1:0] a_base, a_base_next, b_ptr, b_ptr_next;

  logic [DW-1:0]     ar, ac, br, bc, cols, steps;
  logic              echo, accept, k_last, j_last, i_last;
  logic [CNT_W-1:0]  cnt_inc, left_total, right_total;

  function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return DW'(1);
    end else if (int'(v) > MAX_DIM) begin
      return DW'(MAX_DIM);
    end else begin
      return DW'(v);
    end
  endfunction

  always_comb begin
    ar = clamp_dim(a_rows_raw);
    ac = clamp_dim(a_cols_raw);
    br = clamp_dim(b_rows_raw);
    bc = clamp_dim(b_cols_raw);
    echo  = (ac != br);
    cols  = echo ? ac : bc;
    steps = echo ? DW'(1) : ac;
    left_total  = CNT_W'(CNT_W'(ar) * CNT_W'(ac));
    right_total = CNT_W'(CNT_W'(br) * CNT_W'(bc));
    cnt_inc = load_count + CNT_W'(1);
    k_last = (DW'(k) + DW'(1)) == steps;
    j_last = (DW'(j) + DW'(1)) == cols;
    i_last = (DW'(i) + DW'(1)) == ar;
  end

  assign busy   = (state != S_LOAD);
  assign accept = start && !busy;
  assign waddr  = load_count[ADDR_W-1:0];
  assign a_addr = a_base + (echo ? ADDR_W'(j) : ADDR_W'(k));
  assign b_addr = b_ptr;

  always_comb begin
    cmd             = '0;
    cmd.we          = accept;
    cmd.right       = loading_right;
    cmd.rd          = (state == S_RUN);
    cmd.first       = (k == '0);
    cmd.last_step   = k_last;
    cmd.echo        = echo;
    cmd.row         = IDX_W'(i);
    cmd.col         = IDX_W'(j);
    cmd.last_of_run = k_last && j_last && i_last;
  end

  always_comb begin
    state_next         = state;
    load_count_next    = load_count;
    loading_right_next = loading_right;
    i_next      = i;
    j_next      = j;
    k_next      = k;
    a_base_next = a_base;
    b_ptr_next  = b_ptr;
    case (state)
      S_LOAD: begin
        if (accept) begin
          load_count_next = cnt_inc;
          if (!loading_right) begin
            if (cnt_inc >= left_total) begin
              load_count_next    = '0;
              loading_right_next = 1'b1;
            end
          end else if (cnt_inc >= right_total) begin
            load_count_next    = '0;
            loading_right_next = 1'b0;
            state_next  = S_RUN;
            i_next      = '0;
            j_next      = '0;
            k_next      = '0;
            a_base_next = '0;
            b_ptr_next  = '0;
          end
        end
      end
      S_RUN: begin
        if (!k_last) begin
          k_next     = k + IW'(1);
          b_ptr_next = b_ptr + ADDR_W'(bc);
        end else begin
          k_next = '0;
          if (!j_last) begin
            j_next     = j + IW'(1);
            b_ptr_next = ADDR_W'(j) + ADDR_W'(1);
          end else begin
            j_next      = '0;
            b_ptr_next  = '0;
            a_base_next = a_base + ADDR_W'(ac);
            if (i_last) begin
              state_next = S_DRAIN;
            end else begin
              i_next = i + IW'(1);
            end
          end
        end
      end
      S_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      load_count    <= '0;
      loading_right <= 1'b0;
      i      <= '0;
      j      <= '0;
      k      <= '0;
      a_base <= '0;
      b_ptr  <= '0;
    end else begin
      state         <= state_next;
      load_count    <= load_count_next;
      loading_right <= loading_right_next;
      i      <= i_next;
      j      <= j_next;
      k      <= k_next;
      a_base <= a_base_next;
      b_ptr  <= b_ptr_next;
    end
  end

endmodule

### hdl/mm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_datapath
// Element stores, registered reads, signed multiply, exact accumulate, then shift by
// the fraction width and saturate into the result register; echoed A words pass through.
// ----------------------------------------------------------------------------
module mm_datapath #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16,
  parameter int ADDR_W    = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mm_pkg::cmd_t                      cmd,
  input  logic [ADDR_W-1:0]                 waddr,
  input  logic [ADDR_W-1:0]                 a_addr,
  input  logic [ADDR_W-1:0]                 b_addr,
  input  logic signed [mm_pkg::ELEM_W-1:0]  wdata,
  output mm_pkg::status_t                   status,
  output logic                              result_valid,
  output logic signed [mm_pkg::ELEM_W-1:0]  product_value,
  output logic [mm_pkg::IDX_W-1:0]          out_row,
  output logic [mm_pkg::IDX_W-1:0]          out_col,
  output logic                              last_of_run,
  output logic                              dim_error
);
  import mm_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;
  localparam int HI_W   = ACC_W - ELEM_W + 1;

  logic [ELEM_W-1:0] left_store  [DEPTH];
  logic [ELEM_W-1:0] right_store [DEPTH];

  logic                     v1, v2, v3;
  cmd_t                     t1, t2, t3;
  logic signed [ELEM_W-1:0] a_q, b_q;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc, shifted;
  logic [HI_W-1:0]          hi;
  logic                     fits;
  logic [ELEM_W-1:0]        sat_value;

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      if (cmd.right) begin
        right_store[waddr] <= wdata;
      end else begin
        left_store[waddr] <= wdata;
      end
    end
    if (cmd.rd) begin
      a_q <= left_store[a_addr];
      b_q <= right_store[b_addr];
    end
  end

  always_ff @(posedge clk) begin
    t1 <= cmd;
    t2 <= t1;
    t3 <= t2;
    if (t1.echo) begin
      prod <= {{ELEM_W{a_q[ELEM_W-1]}}, a_q};
    end else begin
      prod <= a_q * b_q;
    end
    if (v2) begin
      acc <= t2.first ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

  always_comb begin
    shifted = acc >>> FRAC_BITS;
    hi      = shifted[ACC_W-1:ELEM_W-1];
    fits    = (&hi) || !(|hi);
    if (fits) begin
      sat_value = shifted[ELEM_W-1:0];
    end else if (acc[ACC_W-1]) begin
      sat_value = {1'b1, {(ELEM_W-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(ELEM_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (v3 && t3.last_step) begin
      product_value <= t3.echo ? acc[ELEM_W-1:0] : sat_value;
      out_row       <= t3.row;
      out_col       <= t3.col;
      last_of_run   <= t3.last_of_run;
      dim_error     <= t3.echo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      v1 <= cmd.rd;
      v2 <= v1;
      v3 <= v2;
      result_valid <= v3 && t3.last_step;
    end
  end

  assign status.pipe_busy = v1 || v2 || v3;

endmodule

### hdl/matrix_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply
// Dense Q16.16 matrix multiplier: loads A then B row-major, emits C = A * B
// row by row, or echoes A with dim_error when the inner dimensions differ.
// ----------------------------------------------------------------------------
//  channel   signals                                         handshake
//  input     start, busy, element                            start && !busy
//  result    result_valid, product_value, out_row, out_col,  one-cycle strobe
//            last_of_run, dim_error
//  config    psel, penable, pwrite, paddr, pwdata, prdata,   APB, pready = 1
//            pready
//
//  Loading accepts words back to back; busy stays low until the last B word.
//  The run then issues one store read per cycle, a_rows * b_cols * a_cols
//  reads (a_rows * a_cols on a dimension error), through a four-stage
//  read, multiply, accumulate and saturate pipeline; busy falls the cycle
//  after the last result. Results cannot be stalled. rst is synchronous.
// ----------------------------------------------------------------------------
module matrix_multiply #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [mm_pkg::ELEM_W-1:0]   element,
  output logic                               result_valid,
  output logic signed [mm_pkg::ELEM_W-1:0]   product_value,
  output logic [mm_pkg::IDX_W-1:0]           out_row,
  output logic [mm_pkg::IDX_W-1:0]           out_col,
  output logic                               last_of_run,
  output logic                               dim_error,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mm_pkg::PADDR_W-1:0]         paddr,
  input  logic [mm_pkg::PDATA_W-1:0]         pwdata,
  output logic [mm_pkg::PDATA_W-1:0]         prdata,
  output logic                               pready
);
  import mm_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  logic [CFG_W-1:0]  a_rows, a_cols, b_rows, b_cols;
  logic [1:0]        reg_sel;
  logic              cfg_write;
  cmd_t              cmd;
  status_t           status;
  logic [ADDR_W-1:0] waddr, a_addr, b_addr;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows <= CFG_W'(1);
      a_cols <= CFG_W'(1);
      b_rows <= CFG_W'(1);
      b_cols <= CFG_W'(1);
    end else if (cfg_write) begin
      case (reg_sel)
        REG_A_ROWS: a_rows <= pwdata[CFG_W-1:0];
        REG_A_COLS: a_cols <= pwdata[CFG_W-1:0];
        REG_B_ROWS: b_rows <= pwdata[CFG_W-1:0];
        REG_B_COLS: b_cols <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_A_ROWS: prdata = PDATA_W'(a_rows);
      REG_A_COLS: prdata = PDATA_W'(a_cols);
      REG_B_ROWS: prdata = PDATA_W'(b_rows);
      REG_B_COLS: prdata = PDATA_W'(b_cols);
      default:    prdata = '0;
    endcase
  end

  mm_ctrl #(
    .MAX_DIM (MAX_DIM),
    .ADDR_W  (ADDR_W),
    .CNT_W   (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .a_rows_raw (a_rows),
    .a_cols_raw (a_cols),
    .b_rows_raw (b_rows),
    .b_cols_raw (b_cols),
    .status     (status),
    .busy       (busy),
    .cmd        (cmd),
    .waddr      (waddr),
    .a_addr     (a_addr),
    .b_addr     (b_addr)
  );

  mm_datapath #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS),
    .ADDR_W    (ADDR_W)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .waddr         (waddr),
    .a_addr        (a_addr),
    .b_addr        (b_addr),
    .wdata         (element),
    .status        (status),
    .result_valid  (result_valid),
    .product_value (product_value),
    .out_row       (out_row),
    .out_col       (out_col),
    .last_of_run   (last_of_run),
    .dim_error     (dim_error)
  );

endmodule

### hdl/mm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_checker
// Port-level checks on the matrix multiplier: results only during a run,
// a run ends on its last word, and the error flag holds across a run.
// ----------------------------------------------------------------------------
module mm_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic result_valid,
  input logic last_of_run,
  input logic dim_error
);

  a_result_in_run: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result word outside a run");

  a_no_result_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !result_valid)
    else $error("result word straight after an accepted word");

  a_run_ends_on_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(result_valid && last_of_run))
    else $error("run ended without its last word");

  a_last_closes_run: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_of_run) |=> (!result_valid && !busy))
    else $error("activity after the last word of a run");

  a_error_flag_holds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && $past(result_valid)) |-> (dim_error == $past(dim_error)))
    else $error("dim_error changed within a run");

endmodule

bind matrix_multiply mm_checker u_mm_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .last_of_run  (last_of_run),
  .dim_error    (dim_error)
);

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for matrix_multiply. A short table of directed words
// and register writes comes first, then random matrices of random shape and
// content, sent in bursts. Register writes are read back over APB. Every
// result word is checked field by field against the table's expected value or
// an in-bench model that tracks the load state, the stores and the dimensions.
// ----------------------------------------------------------------------------
module tb;
  import mm_pkg::*;

  localparam int MAX_DIM       = 8;
  localparam int FRAC_BITS     = 16;
  localparam int RANDOM_WORDS  = 480;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_GUARD     = 20000;
  localparam logic signed [71:0] SAT_HI = 72'sd2147483647;
  localparam logic signed [71:0] SAT_LO = -72'sd2147483648;

  typedef struct packed {
    logic signed [ELEM_W-1:0] value;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic                     last;
    logic                     err;
  } product_t;

  typedef enum logic [1:0] {ROW_REG, ROW_WORD, ROW_WORD_CHECKED} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  idx;
    logic [31:0] data;
    logic [31:0] want_value;
    logic        want_err;
  } step_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic signed [ELEM_W-1:0]  element;
  logic                      result_valid;
  logic signed [ELEM_W-1:0]  product_value;
  logic [IDX_W-1:0]          out_row;
  logic [IDX_W-1:0]          out_col;
  logic                      last_of_run;
  logic                      dim_error;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [PADDR_W-1:0]        paddr;
  logic [PDATA_W-1:0]        pwdata;
  logic [PDATA_W-1:0]        prdata;
  logic                      pready;

  // bench copy of the block state
  logic [3:0]  dim_reg [4];
  logic [31:0] left_mem [MAX_DIM*MAX_DIM];
  logic [31:0] right_mem [MAX_DIM*MAX_DIM];
  int          fill_count;
  logic        filling_right;

  product_t fresh_products [$];
  product_t awaited_products [$];
  step_t    plan [$];

  int failures;
  int words_sent;
  int products_seen;
  int runs_done;
  int echo_runs;
  int burst_left;

  matrix_multiply #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .element(element),
    .result_valid(result_valid), .product_value(product_value),
    .out_row(out_row), .out_col(out_col), .last_of_run(last_of_run),
    .dim_error(dim_error), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int eff_dim(input logic [3:0] v);
    if (v == 4'd0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic logic [3:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 4'd0;
    if (r < 10) return 4'($urandom_range(9, 15));
    if (r < 22) return 4'($urandom_range(5, 8));
    return 4'($urandom_range(1, 4));
  endfunction

  // take one word into the stores; fill fresh_products when B completes
  function automatic void absorb_word(input logic [31:0] w);
    int ar, ac, br, bc, cols, i, j, k;
    logic signed [71:0] acc;
    logic signed [63:0] prod;
    product_t p;
    ar = eff_dim(dim_reg[REG_A_ROWS]);
    ac = eff_dim(dim_reg[REG_A_COLS]);
    br = eff_dim(dim_reg[REG_B_ROWS]);
    bc = eff_dim(dim_reg[REG_B_COLS]);
    fresh_products.delete();
    if (!filling_right) begin
      left_mem[fill_count] = w;
      fill_count++;
      if (fill_count >= ar * ac) begin
        fill_count = 0;
        filling_right = 1'b1;
      end
      return;
    end
    right_mem[fill_count] = w;
    fill_count++;
    if (fill_count < br * bc) return;
    fill_count = 0;
    filling_right = 1'b0;
    cols = (ac == br) ? bc : ac;
    for (i = 0; i < ar; i++) begin
      for (j = 0; j < cols; j++) begin
        if (ac == br) begin
          acc = '0;
          for (k = 0; k < ac; k++) begin
            prod = $signed(left_mem[i*ac+k]) * $signed(right_mem[k*bc+j]);
            acc = acc + prod;
          end
          acc = acc >>> FRAC_BITS;
          if (acc > SAT_HI) p.value = 32'h7FFF_FFFF;
          else if (acc < SAT_LO) p.value = 32'h8000_0000;
          else p.value = acc[31:0];
        end else begin
          p.value = left_mem[i*ac+j];
        end
        p.row  = i[IDX_W-1:0];
        p.col  = j[IDX_W-1:0];
        p.last = (i == ar - 1) && (j == cols - 1);
        p.err  = (ac != br);
        fresh_products.push_back(p);
      end
    end
  endfunction

  function automatic void add_step(input row_kind_t kind, input logic [1:0] idx,
                                   input logic [31:0] data, input logic [31:0] wv,
                                   input logic we);
    step_t s;
    s.kind = kind;
    s.idx = idx;
    s.data = data;
    s.want_value = wv;
    s.want_err = we;
    plan.push_back(s);
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic send_word(input logic [31:0] w, input logic checked,
                           input product_t typed);
    int gap;
    if (burst_left <= 0) begin
      start = 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    start = 1'b1;
    element = w;
    do @(posedge clk); while (busy);
    absorb_word(w);
    words_sent++;
    if (fresh_products.size() != 0) begin
      runs_done++;
      if (fresh_products[0].err) echo_runs++;
    end
    if (checked && fresh_products.size() == 1) awaited_products.push_back(typed);
    else foreach (fresh_products[n]) awaited_products.push_back(fresh_products[n]);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) start = 1'b0;
  endtask

  // hold off until every word is back and the pipeline has emptied
  task automatic let_block_settle();
    start = 1'b0;
    while (awaited_products.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_register(input logic [1:0] idx, input logic [3:0] v);
    logic [PDATA_W-1:0] got;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = {$urandom} & ~32'hF | {28'd0, v};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    dim_reg[idx] = v;
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    if (got !== {28'd0, v}) begin
      $error("prdata: expected %h, got %h", {28'd0, v}, got);
      failures++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  always @(posedge clk) begin : watch
    product_t want;
    if (!rst && result_valid) begin
      products_seen++;
      if (awaited_products.size() == 0) begin
        $error("unexpected word: product_value %h out_row %0d out_col %0d",
               product_value, out_row, out_col);
        failures++;
      end else begin
        want = awaited_products.pop_front();
        if (product_value !== want.value) begin
          $error("product_value: expected %h, got %h", want.value, product_value);
          failures++;
        end
        if (out_row !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, out_row);
          failures++;
        end
        if (out_col !== want.col) begin
          $error("out_col: expected %0d, got %0d", want.col, out_col);
          failures++;
        end
        if (last_of_run !== want.last) begin
          $error("last_of_run: expected %b, got %b", want.last, last_of_run);
          failures++;
        end
        if (dim_error !== want.err) begin
          $error("dim_error: expected %b, got %b", want.err, dim_error);
          failures++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    step_t       s;
    product_t    typed;
    logic [3:0]  ar, ac, br, bc;
    logic [31:0] w;
    int          mode, count, rand_words, guard;
    logic        first;

    rst = 1'b1;
    start = 1'b0;
    element = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    failures = 0;
    words_sent = 0;
    products_seen = 0;
    runs_done = 0;
    echo_runs = 0;
    burst_left = 0;
    fill_count = 0;
    filling_right = 1'b0;
    foreach (dim_reg[n]) dim_reg[n] = 4'd1;
    foreach (left_mem[n]) begin
      left_mem[n] = '0;
      right_mem[n] = '0;
    end

    // 1x1 after reset: plain product, both saturations, floor of a negative
    add_step(ROW_WORD, REG_A_ROWS, 32'h0001_0000, '0, 1'b0);
    add_step(ROW_WORD_CHECKED, REG_A_ROWS, 32'h0002_0000, 32'h0002_0000, 1'b0);
    add_step(ROW_WORD, REG_A_ROWS, 32'h8000_0000, '0, 1'b0);
    add_step(ROW_WORD_CHECKED, REG_A_ROWS, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    add_step(ROW_WORD, REG_A_ROWS, 32'h7FFF_FFFF, '0, 1'b0);
    add_step(ROW_WORD_CHECKED, REG_A_ROWS, 32'h8000_0000, 32'h8000_0000, 1'b0);
    add_step(ROW_WORD, REG_A_ROWS, 32'hFFFF_FFFF, '0, 1'b0);
    add_step(ROW_WORD_CHECKED, REG_A_ROWS, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
    add_step(ROW_WORD, REG_A_ROWS, 32'h0000_8000, '0, 1'b0);
    add_step(ROW_WORD_CHECKED, REG_A_ROWS, 32'h0000_8000, 32'h0000_4000, 1'b0);
    // inner dimensions differ: A echoed
    add_step(ROW_REG, REG_B_ROWS, 32'd2, '0, 1'b0);
    add_step(ROW_WORD, REG_A_ROWS, 32'h1234_5678, '0, 1'b0);
    add_step(ROW_WORD, REG_A_ROWS, 32'h0000_0001, '0, 1'b0);
    add_step(ROW_WORD_CHECKED, REG_A_ROWS, 32'h0000_0002, 32'h1234_5678, 1'b1);
    // zero in every register acts as one
    add_step(ROW_REG, REG_A_ROWS, 32'd0, '0, 1'b0);
    add_step(ROW_REG, REG_A_COLS, 32'd0, '0, 1'b0);
    add_step(ROW_REG, REG_B_ROWS, 32'd0, '0, 1'b0);
    add_step(ROW_REG, REG_B_COLS, 32'd0, '0, 1'b0);
    add_step(ROW_WORD, REG_A_ROWS, 32'h0003_0000, '0, 1'b0);
    add_step(ROW_WORD_CHECKED, REG_A_ROWS, 32'h0004_0000, 32'h000C_0000, 1'b0);
    // 2x2 by 2x2
    add_step(ROW_REG, REG_A_ROWS, 32'd2, '0, 1'b0);
    add_step(ROW_REG, REG_A_COLS, 32'd2, '0, 1'b0);
    add_step(ROW_REG, REG_B_ROWS, 32'd2, '0, 1'b0);
    add_step(ROW_REG, REG_B_COLS, 32'd2, '0, 1'b0);
    add_step(ROW_WORD, REG_A_ROWS, 32'h0001_8000, '0, 1'b0);
    add_step(ROW_WORD, REG_A_ROWS, 32'hFFFE_0000, '0, 1'b0);
    add_step(ROW_WORD, REG_A_ROWS, 32'h7FFF_FFFF, '0, 1'b0);
    add_step(ROW_WORD, REG_A_ROWS, 32'h0000_0003, '0, 1'b0);
    add_step(ROW_WORD, REG_A_ROWS, 32'h0002_0000, '0, 1'b0);
    add_step(ROW_WORD, REG_A_ROWS, 32'h8000_0000, '0, 1'b0);
    add_step(ROW_WORD, REG_A_ROWS, 32'hFFFF_8000, '0, 1'b0);
    add_step(ROW_WORD, REG_A_ROWS, 32'h0100_0000, '0, 1'b0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[n]) begin
      s = plan[n];
      typed.value = s.want_value;
      typed.row = '0;
      typed.col = '0;
      typed.last = 1'b1;
      typed.err = s.want_err;
      case (s.kind)
        ROW_REG: begin
          let_block_settle();
          set_register(s.idx, s.data[3:0]);
        end
        ROW_WORD: send_word(s.data, 1'b0, typed);
        ROW_WORD_CHECKED: send_word(s.data, 1'b1, typed);
        default: ;
      endcase
    end

    rand_words = 0;
    first = 1'b1;
    while (rand_words < RANDOM_WORDS) begin
      if (first || $urandom_range(0, 9) < 7) begin
        let_block_settle();
        ar = pick_dim();
        ac = pick_dim();
        br = ($urandom_range(0, 99) < 85) ? ac : pick_dim();
        bc = pick_dim();
        set_register(REG_A_ROWS, ar);
        set_register(REG_A_COLS, ac);
        set_register(REG_B_ROWS, br);
        set_register(REG_B_COLS, bc);
        first = 1'b0;
      end
      mode = $urandom_range(0, 2);
      count = eff_dim(dim_reg[REG_A_ROWS]) * eff_dim(dim_reg[REG_A_COLS]) +
              eff_dim(dim_reg[REG_B_ROWS]) * eff_dim(dim_reg[REG_B_COLS]);
      repeat (count) begin
        case (mode)
          0: w = $urandom;
          1: w = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
          default: begin
            case ($urandom_range(0, 4))
              0: w = 32'h8000_0000;
              1: w = 32'h7FFF_FFFF;
              2: w = 32'h0000_0000;
              3: w = 32'hFFFF_FFFF;
              default: w = 32'h0001_0000;
            endcase
          end
        endcase
        send_word(w, 1'b0, typed);
        rand_words++;
      end
    end

    start = 1'b0;
    for (guard = 0; guard < END_GUARD && awaited_products.size() != 0; guard++)
      @(posedge clk);
    if (awaited_products.size() != 0) begin
      $error("%0d result words never arrived", awaited_products.size());
      failures++;
    end
    repeat (4 * SETTLE_CYCLES) @(posedge clk);

    $display("tb: %0d words loaded, %0d matrix runs (%0d with mismatched inner size)",
             words_sent, runs_done, echo_runs);
    $display("tb: %0d result words checked, %0d faults", products_seen, failures);
    if (failures == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
